FILE: design/srt_pkg.sv
// ============================================================================
// srt_pkg
// Shared codes and types for the sorted record table and its cells.
// ============================================================================
package srt_pkg;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_FIND     = 3'd2,
        OP_CATEGORY = 3'd3,
        OP_LIST     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_ENTRY     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      in_use;
    } cell_ctrl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

FILE: design/sorted_record_table.sv
// ============================================================================
// sorted_record_table
// Key-ordered record table built as a row of cells; insert, delete, find by
// key, category search and full listing.
// ============================================================================
//  channel   ports                                         direction
//  request   s_valid s_ready s_op s_key s_category         in
//  result    m_valid m_ready m_status m_out_key
//            m_out_category m_last                          out
//
//  Insert, delete and find by key pass through accept (S_IDLE) and S_EXEC,
//  where every cell compares in parallel and a successful insert or delete
//  shifts the affected slots by one. Category search and listing go from
//  S_EXEC to S_SCAN, rotate the whole row through slot 0, then flush.
//  Reset (aresetn low, synchronous) empties the table; no clearing pass.
//  A stalled result register holds the rotation and the single-step ops.
// ============================================================================
module sorted_record_table
    import srt_pkg::*;
#(
    parameter int DEPTH         = 32,
    parameter int KEY_BITS      = 16,
    parameter int CATEGORY_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_op,
    input  logic [KEY_BITS-1:0]      s_key,
    input  logic [CATEGORY_BITS-1:0] s_category,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [KEY_BITS-1:0]      m_out_key,
    output logic [CATEGORY_BITS-1:0] m_out_category,
    output logic                     m_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FLUSH} state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               op_reg, op_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [CATEGORY_BITS-1:0] cat_reg, cat_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic [KEY_BITS-1:0]      hold_key_reg, hold_key_next;
    logic [CATEGORY_BITS-1:0] hold_cat_reg, hold_cat_next;
    logic                     m_valid_reg, m_valid_next;
    logic [2:0]               m_status_reg, m_status_next;
    logic [KEY_BITS-1:0]      m_key_reg, m_key_next;
    logic [CATEGORY_BITS-1:0] m_cat_reg, m_cat_next;
    logic                     m_last_reg, m_last_next;

    logic [KEY_BITS-1:0]      cell_key [DEPTH];
    logic [CATEGORY_BITS-1:0] cell_cat [DEPTH];
    cell_flags_t              cell_flags [DEPTH];
    cell_ctrl_t               cell_ctrl [DEPTH];
    cell_cmd_t                cmd_ins [DEPTH];
    cell_cmd_t                cmd_del [DEPTH];
    cell_cmd_t                cell_cmd [DEPTH];

    logic                     hit;
    logic                     full;
    logic                     out_free;
    logic                     match0;
    logic [CATEGORY_BITS-1:0] found_cat;

    // ---------------- cell row ----------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int PREV = (i + DEPTH - 1) % DEPTH;
        localparam int NEXT = (i + 1) % DEPTH;

        assign cell_ctrl[i] = {cell_cmd[i], (CNT_W'(i) < count_reg)};

        // open the slot at the insert position, push larger keys up
        if (i == 0) begin : g_first
            assign cmd_ins[i] = cell_flags[i].lt ? CELL_HOLD : CELL_LOAD;
        end else begin : g_rest
            assign cmd_ins[i] = !cell_flags[i-1].lt ? CELL_FROM_PREV :
                                (!cell_flags[i].lt ? CELL_LOAD : CELL_HOLD);
        end
        // close the gap: every slot at or above the deleted key pulls down
        assign cmd_del[i] = cell_flags[i].lt ? CELL_HOLD : CELL_FROM_NEXT;

        srt_cell #(
            .KEY_BITS      (KEY_BITS),
            .CATEGORY_BITS (CATEGORY_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl[i]),
            .req_key  (key_reg),
            .req_cat  (cat_reg),
            .prev_key (cell_key[PREV]),
            .prev_cat (cell_cat[PREV]),
            .next_key (cell_key[NEXT]),
            .next_cat (cell_cat[NEXT]),
            .key      (cell_key[i]),
            .cat      (cell_cat[i]),
            .flags    (cell_flags[i])
        );
    end

    always_comb begin
        hit       = 1'b0;
        found_cat = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit       = hit | cell_flags[i].eq;
            found_cat = found_cat | (cell_flags[i].eq ? cell_cat[i] : '0);
        end
    end

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign match0   = (CNT_W'(idx_reg) < count_reg) &&
                      ((op_reg == OP_LIST) || (cell_cat[0] == cat_reg));

    // ---------------- control ----------------
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        cat_next        = cat_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_key_next   = hold_key_reg;
        hold_cat_next   = hold_cat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_cat_next      = m_cat_reg;
        m_last_next     = m_last_reg;
        for (int i = 0; i < DEPTH; i++) begin
            cell_cmd[i] = CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    key_next   = s_key;
                    cat_next   = s_category;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (op_reg) inside
                    OP_INSERT, OP_DELETE, OP_FIND: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            m_key_next   = '0;
                            m_cat_next   = '0;
                            state_next   = S_IDLE;
                            if (op_reg == OP_INSERT) begin
                                if (hit) begin
                                    m_status_next = ST_DUPLICATE;
                                end else if (full) begin
                                    m_status_next = ST_FULL;
                                end else begin
                                    m_status_next = ST_DONE;
                                    count_next    = count_reg + 1'b1;
                                    cell_cmd      = cmd_ins;
                                end
                            end else if (!hit) begin
                                m_status_next = ST_NOT_FOUND;
                            end else if (op_reg == OP_DELETE) begin
                                m_status_next = ST_DONE;
                                count_next    = count_reg - 1'b1;
                                cell_cmd      = cmd_del;
                            end else begin
                                m_status_next = ST_ENTRY;
                                m_key_next    = key_reg;
                                m_cat_next    = found_cat;
                            end
                        end
                    end
                    OP_CATEGORY, OP_LIST: begin
                        idx_next        = '0;
                        hold_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (out_free) begin
                    // rotate the row by one slot toward slot 0
                    for (int i = 0; i < DEPTH; i++) begin
                        cell_cmd[i] = CELL_FROM_NEXT;
                    end
                    if (match0) begin
                        if (hold_valid_reg) begin
                            m_valid_next  = 1'b1;
                            m_status_next = ST_ENTRY;
                            m_key_next    = hold_key_reg;
                            m_cat_next    = hold_cat_reg;
                            m_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_key_next   = cell_key[0];
                        hold_cat_next   = cell_cat[0];
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(DEPTH - 1)) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (hold_valid_reg) begin
                        m_status_next = ST_ENTRY;
                        m_key_next    = hold_key_reg;
                        m_cat_next    = hold_cat_reg;
                    end else begin
                        m_status_next = (op_reg == OP_LIST) ? ST_EMPTY : ST_NOT_FOUND;
                        m_key_next    = '0;
                        m_cat_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        cat_reg      <= cat_next;
        hold_key_reg <= hold_key_next;
        hold_cat_reg <= hold_cat_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_cat_reg    <= m_cat_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_key      = m_key_reg;
    assign m_out_category = m_cat_reg;
    assign m_last         = m_last_reg;

endmodule

FILE: design/srt_cell.sv
// ============================================================================
// srt_cell
// One table slot: holds a record, compares its key with the request key and
// loads from the request or from either neighbor on command.
// ============================================================================
module srt_cell
    import srt_pkg::*;
#(
    parameter int KEY_BITS      = 16,
    parameter int CATEGORY_BITS = 16
) (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic [KEY_BITS-1:0]      req_key,
    input  logic [CATEGORY_BITS-1:0] req_cat,
    input  logic [KEY_BITS-1:0]      prev_key,
    input  logic [CATEGORY_BITS-1:0] prev_cat,
    input  logic [KEY_BITS-1:0]      next_key,
    input  logic [CATEGORY_BITS-1:0] next_cat,
    output logic [KEY_BITS-1:0]      key,
    output logic [CATEGORY_BITS-1:0] cat,
    output cell_flags_t              flags
);

    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [CATEGORY_BITS-1:0] cat_reg, cat_next;

    always_comb begin
        key_next = key_reg;
        cat_next = cat_reg;
        case (ctrl.cmd)
            CELL_LOAD: begin
                key_next = req_key;
                cat_next = req_cat;
            end
            CELL_FROM_PREV: begin
                key_next = prev_key;
                cat_next = prev_cat;
            end
            CELL_FROM_NEXT: begin
                key_next = next_key;
                cat_next = next_cat;
            end
            default: begin
                key_next = key_reg;
                cat_next = cat_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        cat_reg <= cat_next;
    end

    assign key      = key_reg;
    assign cat      = cat_reg;
    assign flags.lt = ctrl.in_use && (key_reg < req_key);
    assign flags.eq = ctrl.in_use && (key_reg == req_key);

endmodule
